// ===== rtl/tsb_pkg.sv =====
// Shared constants, codes and types of the tile slice blitter.
package tsb_pkg;

    localparam int CANVAS_WIDTH  = 256;
    localparam int CANVAS_HEIGHT = 128;
    localparam int ROW_BYTES     = (CANVAS_WIDTH + 7) / 8;
    localparam int STORE_BYTES   = ROW_BYTES * CANVAS_HEIGHT;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int PXW           = 12;
    localparam int LANES         = 8;

    typedef enum logic [1:0] {
        ACT_DRAW         = 2'd0,
        ACT_MASKED_WRITE = 2'd1,
        ACT_READ         = 2'd2,
        ACT_CLEAR        = 2'd3
    } action_t;

    localparam logic [1:0] REG_SLICE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SLICE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SLICE_MODE   = 2'd2;

    localparam logic [1:0] MODE_1BPP = 2'd1;
    localparam logic [1:0] MODE_2BPP = 2'd2;

    typedef struct packed {
        logic           en;
        logic           color;
        logic [PXW-1:0] px;
    } lane_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr0;
        logic [ADDR_W-1:0] addr1;
        logic [7:0]        mask0;
        logic [7:0]        val0;
        logic [7:0]        mask1;
        logic [7:0]        val1;
        logic              rd_sel;
    } plan_t;

endpackage

// ===== rtl/tsb_lane.sv =====
// One pixel lane: column, clipping and color of one pixel of a source byte.
module tsb_lane (
    input  logic [2:0]          lane_idx,
    input  logic [1:0]          mode,
    input  logic [7:0]          width,
    input  logic [5:0]          source_byte,
    input  logic [7:0]          data,
    input  logic signed [8:0]   origin_x,
    input  logic                row_ok,
    output tsb_pkg::lane_t      lane
);

    logic [8:0]              col;
    logic                    draw;
    logic                    color;
    logic                    px_ok;
    logic [1:0]              pair;
    logic [tsb_pkg::PXW-1:0] px;

    always_comb begin
        pair = 2'(data >> {~lane_idx[1:0], 1'b0});
        case (mode)
            tsb_pkg::MODE_1BPP: begin
                col   = {source_byte, 3'b000} + 9'(lane_idx);
                draw  = 1'b1;
                color = data[~lane_idx];
            end
            tsb_pkg::MODE_2BPP: begin
                col   = {1'b0, source_byte, 2'b00} + 9'(lane_idx[1:0]);
                draw  = !lane_idx[2] && !pair[1];
                color = pair[0];
            end
            default: begin
                col   = {source_byte, 3'b000} + 9'(lane_idx);
                draw  = 1'b0;
                color = 1'b0;
            end
        endcase
        px    = tsb_pkg::PXW'(origin_x) + tsb_pkg::PXW'(col);
        px_ok = !px[tsb_pkg::PXW-1] &&
                (px[tsb_pkg::PXW-2:0] < (tsb_pkg::PXW-1)'(tsb_pkg::CANVAS_WIDTH));
        lane.en    = row_ok && draw && (col < {1'b0, width}) && px_ok;
        lane.color = color;
        lane.px    = px;
    end

endmodule

// ===== rtl/tsb_merge.sv =====
// Merges the pixel lanes into masks and values for two adjacent canvas bytes.
module tsb_merge (
    input  tsb_pkg::lane_t              lanes [tsb_pkg::LANES],
    input  logic [tsb_pkg::ADDR_W-1:0]  row_base,
    output tsb_pkg::plan_t              plan
);

    logic [tsb_pkg::PXW-4:0] bx0;
    logic [15:0]             wmask;
    logic [15:0]             wval;
    logic [3:0]              pos;

    always_comb begin
        bx0   = lanes[0].px[tsb_pkg::PXW-1:3];
        wmask = '0;
        wval  = '0;
        pos   = '0;
        for (int i = 0; i < tsb_pkg::LANES; i++) begin
            if (lanes[i].en) begin
                pos = {lanes[i].px[tsb_pkg::PXW-1:3] != bx0, lanes[i].px[2:0]};
                wmask[4'd15 - pos] = 1'b1;
                wval[4'd15 - pos]  = lanes[i].color;
            end
        end
        plan.addr0  = row_base + tsb_pkg::ADDR_W'($signed(bx0));
        plan.addr1  = plan.addr0 + tsb_pkg::ADDR_W'(1);
        plan.mask0  = wmask[15:8];
        plan.val0   = wval[15:8];
        plan.mask1  = wmask[7:0];
        plan.val1   = wval[7:0];
        plan.rd_sel = 1'b0;
    end

endmodule

// ===== rtl/tile_slice_blitter_top.sv =====
// Top level of the tile slice blitter: canvas store, sequencer and stream ports.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tuser action, s_tdata placement, data, mask, address
//  m_       out  m_tvalid/m_tready  m_tdata read_data, ignored
//  cfg_     in   cfg_wr_en          cfg_index, cfg_wdata
//
// Draw, masked write and read pass through the calc, read and two write steps before done:
// the single-write-port canvas store needs a read and two byte writes per word.
// Clear walks the whole store, one canvas byte written per cycle.
// After reset a clearing pass over the whole store runs before the first accept.
// A result waits in the output register; the sequencer stalls only when it is full.
module tile_slice_blitter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [8:0] origin_x, [17:9] origin_y, [25:18] source_row, [31:26] source_byte,
    // [39:32] data, [47:40] mask, [59:48] canvas_address, [63:60] zero
    input  logic [63:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [8] ignored, [15:9] zero
    output logic [15:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    localparam int AW = tsb_pkg::ADDR_W;

    typedef enum logic [2:0] {
        S_RESET_CLR,
        S_IDLE,
        S_CALC,
        S_READ,
        S_WR0,
        S_WR1,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           clr_reg;
    logic                    clr_last;

    logic [7:0]              width_reg;
    logic [7:0]              height_reg;
    logic [1:0]              mode_reg;

    tsb_pkg::action_t        act_reg;
    logic signed [8:0]       ox_reg;
    logic signed [8:0]       oy_reg;
    logic [7:0]              row_reg;
    logic [5:0]              sbyte_reg;
    logic [7:0]              data_reg;
    logic [7:0]              mask_reg;
    logic [11:0]             caddr_reg;

    logic [tsb_pkg::PXW-1:0] py;
    logic                    row_in;
    logic                    row_ok;
    logic                    addr_ok;
    logic [AW-1:0]           row_base;
    tsb_pkg::lane_t          lanes [tsb_pkg::LANES];
    tsb_pkg::plan_t          draw_plan;
    tsb_pkg::plan_t          plan_next;
    tsb_pkg::plan_t          plan_reg;
    logic                    ign_reg;

    logic [7:0]              mem [tsb_pkg::STORE_BYTES];
    logic [7:0]              rd0_reg;
    logic [7:0]              rd1_reg;
    logic                    mem_we;
    logic [AW-1:0]           mem_wa;
    logic [7:0]              mem_wd;

    logic                    m_tvalid_reg;
    logic [15:0]             m_tdata_reg;
    logic                    accept;
    logic                    out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign clr_last = (clr_reg == AW'(tsb_pkg::STORE_BYTES - 1));

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 8'd8;
            height_reg <= 8'd8;
            mode_reg   <= tsb_pkg::MODE_1BPP;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tsb_pkg::REG_SLICE_WIDTH:  width_reg  <= cfg_wdata;
                tsb_pkg::REG_SLICE_HEIGHT: height_reg <= cfg_wdata;
                tsb_pkg::REG_SLICE_MODE:   mode_reg   <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // draw geometry
    always_comb begin
        py       = tsb_pkg::PXW'(oy_reg) + tsb_pkg::PXW'(row_reg);
        row_in   = (row_reg < height_reg);
        row_ok   = row_in && !py[tsb_pkg::PXW-1] &&
                   (py[tsb_pkg::PXW-2:0] < (tsb_pkg::PXW-1)'(tsb_pkg::CANVAS_HEIGHT));
        row_base = AW'(AW'(py[tsb_pkg::PXW-2:0]) * AW'(tsb_pkg::ROW_BYTES));
        addr_ok  = (32'(caddr_reg) < 32'(tsb_pkg::STORE_BYTES));
    end

    for (genvar g = 0; g < tsb_pkg::LANES; g++) begin : g_lane
        tsb_lane u_lane (
            .lane_idx    (3'(g)),
            .mode        (mode_reg),
            .width       (width_reg),
            .source_byte (sbyte_reg),
            .data        (data_reg),
            .origin_x    (ox_reg),
            .row_ok      (row_ok),
            .lane        (lanes[g])
        );
    end

    tsb_merge u_merge (
        .lanes    (lanes),
        .row_base (row_base),
        .plan     (draw_plan)
    );

    always_comb begin
        plan_next        = draw_plan;
        plan_next.addr0  = AW'(caddr_reg);
        plan_next.addr1  = AW'(caddr_reg);
        plan_next.mask0  = '0;
        plan_next.mask1  = '0;
        plan_next.val0   = data_reg;
        plan_next.rd_sel = 1'b0;
        unique case (act_reg)
            tsb_pkg::ACT_DRAW:         plan_next = draw_plan;
            tsb_pkg::ACT_MASKED_WRITE: plan_next.mask0 = addr_ok ? mask_reg : 8'h00;
            tsb_pkg::ACT_READ:         plan_next.rd_sel = addr_ok;
            tsb_pkg::ACT_CLEAR:        ;
        endcase
    end

    // canvas store port
    always_comb begin
        mem_we = 1'b0;
        mem_wa = clr_reg;
        mem_wd = '0;
        unique case (state_reg)
            S_RESET_CLR, S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_WR0: begin
                mem_we = |plan_reg.mask0;
                mem_wa = plan_reg.addr0;
                mem_wd = (rd0_reg & ~plan_reg.mask0) | (plan_reg.val0 & plan_reg.mask0);
            end
            S_WR1: begin
                mem_we = |plan_reg.mask1;
                mem_wa = plan_reg.addr1;
                mem_wd = (rd1_reg & ~plan_reg.mask1) | (plan_reg.val1 & plan_reg.mask1);
            end
            S_IDLE, S_CALC, S_READ, S_DONE: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (state_reg == S_READ) begin
            rd0_reg <= mem[plan_reg.addr0];
            rd1_reg <= mem[plan_reg.addr1];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_RESET_CLR: if (clr_last) state_next = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    state_next = (tsb_pkg::action_t'(s_tuser) == tsb_pkg::ACT_CLEAR)
                                 ? S_CLEAR : S_CALC;
                end
            end
            S_CALC:  state_next = S_READ;
            S_READ:  state_next = S_WR0;
            S_WR0:   state_next = S_WR1;
            S_WR1:   state_next = S_DONE;
            S_CLEAR: if (clr_last) state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_RESET_CLR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_RESET_CLR || state_reg == S_CLEAR) begin
                clr_reg <= clr_last ? '0 : clr_reg + AW'(1);
            end
            if (accept) begin
                act_reg   <= tsb_pkg::action_t'(s_tuser);
                ox_reg    <= s_tdata[8:0];
                oy_reg    <= s_tdata[17:9];
                row_reg   <= s_tdata[25:18];
                sbyte_reg <= s_tdata[31:26];
                data_reg  <= s_tdata[39:32];
                mask_reg  <= s_tdata[47:40];
                caddr_reg <= s_tdata[59:48];
                ign_reg   <= 1'b0;
            end
            if (state_reg == S_CALC) begin
                plan_reg <= plan_next;
                ign_reg  <= (act_reg == tsb_pkg::ACT_DRAW) && !row_in;
            end
            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {7'b0, ign_reg,
                                 (act_reg == tsb_pkg::ACT_READ && plan_reg.rd_sel)
                                 ? rd0_reg : 8'h00};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the done step");

    a_ignored_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[7:0] == 8'h00))
        else $error("ignored draw carries read data");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR || state_reg == S_RESET_CLR) |-> !(s_tvalid && s_tready))
        else $error("word accepted during canvas clear");

    a_draw_writes_only_planned: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == S_WR0) |-> (plan_reg.mask0 != 8'h00))
        else $error("canvas write without mask");
`endif

endmodule
